// File: design/modbus_rtu_request_deframer_macros.svh
// Assertion macros for the Modbus RTU request deframer.
`ifndef MODBUS_RTU_REQUEST_DEFRAMER_MACROS_SVH
`define MODBUS_RTU_REQUEST_DEFRAMER_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, reset disables
`define MRD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, reset disables
`define MRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MRD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define MRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: design/mrd_pkg.sv
// Types, codes and helper functions of the Modbus RTU request deframer.
`default_nettype none
package mrd_pkg;

	localparam int MAX_FRAME_DEF = 256;
	localparam int CFG_IDX_W     = 8;
	localparam int CFG_DATA_W    = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_UNIT_ID = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SILENCE = 8'd1;

	localparam logic [7:0]  UNIT_ID_RST = 8'd1;
	localparam logic [15:0] SILENCE_RST = 16'd35;

	// function codes with special handling
	localparam logic [7:0] FC_COIL_RD      = 8'd1;
	localparam logic [7:0] FC_READ_INPUTS  = 8'd4;
	localparam logic [7:0] FC_HREG_WR1     = 8'd6;
	localparam logic [7:0] FC_COIL_WRN     = 8'd15;
	localparam logic [7:0] FC_HREG_WRN     = 8'd16;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// input item kinds
	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_VALID    = 3'd1,
		EV_CRC_ERR  = 3'd2,
		EV_DISCARD  = 3'd3,
		EV_TIMEOUT  = 3'd4
	} frame_event_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]   byte_out;
		logic [7:0]   byte_position;
		logic         is_payload;
		frame_event_t frame_event;
		logic [7:0]   function_code;
		logic [15:0]  start_address;
		logic [15:0]  quantity;
		logic [7:0]   data_bytes;
		logic [7:0]   pdu_length;
	} out_item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] wdata;
	} cfg_item_t;

	// one byte of CRC-16/MODBUS, reflected, LSB first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic fc_known(input logic [7:0] fc);
		return (fc >= FC_COIL_RD && fc <= FC_HREG_WR1) ||
			fc == FC_COIL_WRN || fc == FC_HREG_WRN;
	endfunction

endpackage
`default_nettype wire

// File: design/mrd_stream_if.sv
// Valid/ready channel carrying one item of a given payload type.
`default_nettype none
interface mrd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/modbus_rtu_request_deframer.sv
// Top level of the Modbus RTU request deframer, slave side.
`default_nettype none
`include "modbus_rtu_request_deframer_macros.svh"
// Every input item (a received byte or one time tick) gives exactly one result item.
// An item is registered in the input register on acceptance, decoded and CRC-updated there,
// and lands in the result register, from which the result is offered; throughput is one item
// per cycle while the result side takes items. The byte-wide CRC-16 update and the frame
// position decode sit in that single stage. A result waiting in the output register stalls
// the input register; a new item still enters while the input register is empty.
// Configuration writes are always ready and take effect at once; write them only while no
// item is in flight.
module modbus_rtu_request_deframer #(
	parameter int MAX_FRAME = mrd_pkg::MAX_FRAME_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	mrd_stream_if.sink   cfg,
	mrd_stream_if.sink   req,
	mrd_stream_if.source res
);

	localparam int PW = $clog2(MAX_FRAME);

	// configuration registers
	logic [7:0]  unit_id_q;
	logic [15:0] silence_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_id_q <= mrd_pkg::UNIT_ID_RST;
			silence_q <= mrd_pkg::SILENCE_RST;
		end else if (cfg.valid) begin
			unique case (cfg.data.idx)
				mrd_pkg::REG_UNIT_ID: unit_id_q <= cfg.data.wdata[7:0];
				mrd_pkg::REG_SILENCE: silence_q <= cfg.data.wdata;
				default: ;
			endcase
		end
	end

	// input register and handshake
	logic             vld_s1;
	mrd_pkg::in_item_t item_s1;
	logic             res_vld_q;
	mrd_pkg::out_item_t res_q;
	logic             advance;

	assign advance   = !res_vld_q || res.ready;
	assign req.ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1 <= req.data;
		end
	end

	// frame state
	logic [PW-1:0] cnt_q, cnt_d;
	logic [15:0]   crc_q, crc_d;
	logic [15:0]   body_q, body_d;
	logic [7:0]    low_q, low_d;
	logic [15:0]   idle_q, idle_d;
	logic          discard_q, discard_d;
	logic [7:0]    hdr_q [7];
	logic [7:0]    hv [7];
	logic          hdr_we;

	// decode temporaries
	logic [7:0]    b;
	logic [15:0]   idle_inc, limit, crc_in, rx_crc, qty_st;
	logic          multi, bad;
	logic [7:0]    bc;
	logic [9:0]    len, p2, p10;
	mrd_pkg::out_item_t o;

	// header view: the byte at the current position comes straight from the item
	always_comb begin
		for (int i = 0; i < 7; i++) begin
			hv[i] = (cnt_q == PW'(i)) ? item_s1.rx_byte : hdr_q[i];
		end
	end

	// next state and result for the item in the input register
	always_comb begin
		cnt_d     = cnt_q;
		crc_d     = crc_q;
		body_d    = body_q;
		low_d     = low_q;
		idle_d    = idle_q;
		discard_d = discard_q;
		hdr_we    = 1'b0;
		o         = '0;
		b         = item_s1.rx_byte;
		idle_inc  = (idle_q != 16'hFFFF) ? idle_q + 16'd1 : idle_q;
		limit     = (silence_q == 16'd0) ? 16'd1 : silence_q;
		p10       = 10'(cnt_q);
		p2        = p10 + 10'd2;
		multi     = (cnt_q >= PW'(1)) &&
			(hv[1] == mrd_pkg::FC_COIL_WRN || hv[1] == mrd_pkg::FC_HREG_WRN);
		bc        = hv[6];
		crc_in    = (cnt_q == '0) ? mrd_pkg::CRC_INIT : crc_q;
		rx_crc    = {b, low_q};
		qty_st    = {hdr_q[4], hdr_q[5]};
		bad       = 1'b0;
		len       = 10'd8;
		if (multi) begin
			len = (cnt_q >= PW'(6)) ? (10'd9 + 10'(bc)) : 10'h3FF;
		end

		if (item_s1.mode == mrd_pkg::MODE_TICK) begin
			// silence tick: count idle time, flush once the limit is reached
			idle_d = idle_inc;
			if (idle_inc >= limit && (cnt_q != '0 || discard_q)) begin
				o.frame_event = mrd_pkg::EV_TIMEOUT;
				discard_d     = 1'b0;
				cnt_d         = '0;
				crc_d         = mrd_pkg::CRC_INIT;
			end
		end else begin
			idle_d     = '0;
			o.byte_out = b;
			if (discard_q) begin
				o.frame_event = mrd_pkg::EV_DISCARD;
			end else begin
				hdr_we          = (cnt_q < PW'(7));
				o.byte_position = 8'(cnt_q);
				if (cnt_q >= PW'(1)) o.function_code = hv[1];
				if (cnt_q >= PW'(3)) o.start_address = {hv[2], hv[3]};
				if (cnt_q >= PW'(5)) o.quantity = {hv[4], hv[5]};
				if (multi && cnt_q >= PW'(6)) o.data_bytes = bc;

				if (cnt_q == PW'(0) && b != unit_id_q) bad = 1'b1;
				if (cnt_q == PW'(1) && !mrd_pkg::fc_known(b)) bad = 1'b1;
				if (cnt_q == PW'(6) && multi && (10'd9 + 10'(bc)) > 10'(MAX_FRAME)) bad = 1'b1;

				if (bad) begin
					o.frame_event = mrd_pkg::EV_DISCARD;
					discard_d     = 1'b1;
					cnt_d         = '0;
					crc_d         = mrd_pkg::CRC_INIT;
				end else begin
					o.is_payload = multi && cnt_q >= PW'(7) && p10 < (10'd7 + 10'(bc));
					if (p2 < len) begin
						// body byte
						crc_d = mrd_pkg::crc16_byte(crc_in, b);
						cnt_d = cnt_q + PW'(1);
					end else if (p2 == len) begin
						// CRC low byte
						crc_d  = crc_in;
						body_d = crc_in;
						low_d  = b;
						cnt_d  = cnt_q + PW'(1);
					end else begin
						// CRC high byte: judge the frame
						if (rx_crc != body_q) begin
							o.frame_event = mrd_pkg::EV_CRC_ERR;
						end else if (hdr_q[1] >= mrd_pkg::FC_COIL_RD &&
							hdr_q[1] <= mrd_pkg::FC_READ_INPUTS && qty_st == 16'd0) begin
							o.frame_event = mrd_pkg::EV_DISCARD;
						end else begin
							o.frame_event = mrd_pkg::EV_VALID;
							o.pdu_length  = 8'(len - 10'd3);
						end
						cnt_d = '0;
						crc_d = mrd_pkg::CRC_INIT;
					end
				end
			end
		end
	end

	// state update when the item moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			crc_q     <= mrd_pkg::CRC_INIT;
			body_q    <= '0;
			low_q     <= '0;
			idle_q    <= '0;
			discard_q <= 1'b0;
		end else if (advance && vld_s1) begin
			cnt_q     <= cnt_d;
			crc_q     <= crc_d;
			body_q    <= body_d;
			low_q     <= low_d;
			idle_q    <= idle_d;
			discard_q <= discard_d;
		end
	end

	// header bytes, written as they arrive
	always_ff @(posedge clk) begin
		if (advance && vld_s1 && hdr_we && item_s1.mode == mrd_pkg::MODE_BYTE) begin
			for (int i = 0; i < 7; i++) begin
				if (cnt_q == PW'(i)) hdr_q[i] <= b;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (advance) begin
			res_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && vld_s1) begin
			res_q <= o;
		end
	end

	assign res.valid = res_vld_q;
	assign res.data  = res_q;

	// checks
	`MRD_ASSERT_NEXT(a_discard_byte, clk, arst_n,
		advance && vld_s1 && item_s1.mode == mrd_pkg::MODE_BYTE && discard_q,
		res.valid && res.data.frame_event == mrd_pkg::EV_DISCARD && res.data.byte_position == 8'd0,
		"byte during discard did not report discard")
	`MRD_ASSERT_NEXT(a_timeout_clears, clk, arst_n,
		advance && vld_s1 && o.frame_event == mrd_pkg::EV_TIMEOUT,
		cnt_q == '0 && !discard_q && crc_q == mrd_pkg::CRC_INIT,
		"timeout flush left frame state behind")
	`MRD_ASSERT_SAME(a_payload_code, clk, arst_n,
		res.valid && res.data.is_payload,
		res.data.function_code == mrd_pkg::FC_COIL_WRN ||
			res.data.function_code == mrd_pkg::FC_HREG_WRN,
		"payload byte outside a write-multiple frame")
	`MRD_ASSERT_SAME(a_valid_len, clk, arst_n,
		res.valid && res.data.frame_event == mrd_pkg::EV_VALID,
		res.data.byte_position == res.data.pdu_length + 8'd2,
		"valid frame length does not match last byte position")

endmodule
`default_nettype wire
